[hw/rtl/attack_release_envelope_assert.svh]
// Assertion macros shared by the envelope RTL.
// Each macro names the assertion, takes an antecedent and a consequent, and
// reports through $error. The clock is clk and the checks pause during rst.
`ifndef ATTACK_RELEASE_ENVELOPE_ASSERT_SVH
`define ATTACK_RELEASE_ENVELOPE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ARE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ARE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/are_pkg.sv]
package are_pkg;

  localparam int CHANNEL_W   = 4;
  localparam int LEVEL_W     = 24;
  localparam int COUNT_W     = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Q1.23 full scale (1.0).
  localparam logic [LEVEL_W-1:0]   FULL_SCALE = 24'h800000;
  // One half in Q0.24, added before the product is cut back to 24 bits.
  localparam logic [2*LEVEL_W-1:0] ROUND_HALF = 48'h0000_0080_0000;
  localparam logic [COUNT_W-1:0]   COUNT_MAX  = 32'hFFFF_FFFF;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_EXP  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_EXP = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_STEP = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_STEP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_COEF = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COEF = 3'd5;

  typedef struct packed {
    logic [CHANNEL_W-1:0] channel;
    logic                 gate_on;
    logic                 restart;
  } are_in_t;

  typedef struct packed {
    logic [CHANNEL_W-1:0] out_channel;
    logic [LEVEL_W-1:0]   level;
    logic [COUNT_W-1:0]   elapsed_samples;
    logic                 in_release;
  } are_out_t;

  // One channel's stored state, one memory word.
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [COUNT_W-1:0] count;
    logic               gate;
  } are_state_t;

endpackage

[hw/rtl/attack_release_envelope.sv]
// Multichannel attack/release envelope. Each input item is one sample tick of
// one channel; the block returns one result item per tick with the channel's
// new Q1.23 level, the number of samples already spent in the current phase
// (saturating) and the phase flag. The block takes one item every clock
// cycle unless the output is stalled, also when consecutive items hit the
// same channel. An accepted item passes the compute stage and then the output
// register before its result is presented. The per-channel state
// (level, phase count, last gate) lives in a memory with a registered read
// port: an item reads its channel's word when it is accepted and writes it
// back when it leaves the compute stage, and the value written last is
// forwarded to the item that follows, so the read-modify-write loop closes
// through one shared 24 x 24 multiplier. Per-channel valid bits, cleared by
// reset, make every channel start at level zero in release with a zero count,
// so no clearing pass is needed. A tick for a channel at or above CHANNELS
// changes no state and returns level zero and elapsed count zero. The
// configuration registers may only be written while no item is in flight.
module attack_release_envelope #(
  parameter int CHANNELS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  are_pkg::are_in_t                  req,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output are_pkg::are_out_t                 rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [are_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [are_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import are_pkg::*;

  `include "attack_release_envelope_assert.svh"

  localparam int AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AXW = AW + CHANNEL_W;

  // Configuration registers.
  logic               attack_exponential;
  logic               release_exponential;
  logic [LEVEL_W-1:0] attack_step;
  logic [LEVEL_W-1:0] release_step;
  logic [LEVEL_W-1:0] attack_coef;
  logic [LEVEL_W-1:0] release_coef;

  // The register file accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_exponential  <= 1'b0;
      release_exponential <= 1'b0;
      attack_step         <= FULL_SCALE;
      release_step        <= FULL_SCALE;
      attack_coef         <= '0;
      release_coef        <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ATTACK_EXP:   attack_exponential  <= cfg_data[0];
        REG_RELEASE_EXP:  release_exponential <= cfg_data[0];
        REG_ATTACK_STEP:  attack_step         <= cfg_data;
        REG_RELEASE_STEP: release_step        <= cfg_data;
        REG_ATTACK_COEF:  attack_coef         <= cfg_data;
        REG_RELEASE_COEF: release_coef        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and address of the incoming item.
  logic           req_accept;
  logic [AXW-1:0] req_ext;
  logic [AW-1:0]  req_addr;
  logic           req_in_range;

  // Compute stage: the item whose memory word is being read out.
  logic           s1_valid;
  are_in_t        s1_item;
  logic [AW-1:0]  s1_addr;
  logic           s1_in_range;
  logic           s1_go;

  // State memory, its valid bits and the read port.
  are_state_t     mem [CHANNELS];
  logic [CHANNELS-1:0] written;
  are_state_t     rd_data;
  logic           rd_written;
  logic           mem_we;

  // Copy of the last word written, for an item that read before that write.
  logic           fwd_valid;
  logic [AW-1:0]  fwd_addr;
  are_state_t     fwd_state;

  // Update datapath.
  are_state_t           st_old;
  are_state_t           st_new;
  logic [LEVEL_W-1:0]   lv_pre;
  logic [COUNT_W-1:0]   cnt_base;
  logic [LEVEL_W-1:0]   mul_a;
  logic [LEVEL_W-1:0]   mul_c;
  logic [2*LEVEL_W-1:0] product;
  logic [2*LEVEL_W-1:0] rounded;
  logic [LEVEL_W-1:0]   scaled;
  logic [LEVEL_W:0]     lin_sum;
  logic [LEVEL_W-1:0]   lv_rise;
  logic [LEVEL_W-1:0]   lv_fall;
  are_out_t             result;

  assign req_accept   = req_valid && req_ready;
  assign req_ext      = AXW'(req.channel);
  assign req_addr     = req_ext[AW-1:0];
  assign req_in_range = int'(req.channel) < CHANNELS;

  // The compute stage moves on whenever the output register is free or being
  // emptied, and a new item may enter whenever the compute stage moves on.
  assign s1_go     = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_go;
  assign mem_we    = s1_valid && s1_go && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      s1_item     <= req;
      s1_addr     <= req_addr;
      s1_in_range <= req_in_range;
    end
  end

  // Synchronous read at acceptance, write-back when the item leaves the
  // compute stage. A read and a write at the same edge return the old word.
  always_ff @(posedge clk) begin
    if (req_accept) begin
      rd_data <= mem[req_addr];
    end
    if (mem_we) begin
      mem[s1_addr] <= st_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (req_accept) begin
        rd_written <= req_in_range && written[req_addr];
      end
      if (mem_we) begin
        written[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (mem_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_addr  <= s1_addr;
      fwd_state <= st_new;
    end
  end

  // Current state of the channel. The forwarded word is never older than the
  // memory word, so it wins whenever the address matches.
  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      st_old = fwd_state;
    end else if (rd_written) begin
      st_old = rd_data;
    end else begin
      st_old = '0;
    end
  end

  always_comb begin
    // A phase change or a restart begins the sample count anew.
    if ((s1_item.gate_on != st_old.gate) || s1_item.restart) begin
      cnt_base = '0;
    end else begin
      cnt_base = st_old.count;
    end

    // A restart presets the level to the start of the phase.
    if (s1_item.restart) begin
      lv_pre = s1_item.gate_on ? '0 : FULL_SCALE;
    end else begin
      lv_pre = st_old.level;
    end

    // One multiplier serves both curves: attack scales the distance to full
    // scale, release scales the level itself.
    mul_a   = s1_item.gate_on ? (FULL_SCALE - lv_pre) : lv_pre;
    mul_c   = s1_item.gate_on ? attack_coef : release_coef;
    product = (2*LEVEL_W)'(mul_a) * (2*LEVEL_W)'(mul_c);
    rounded = product + ROUND_HALF;
    scaled  = rounded[2*LEVEL_W-1:LEVEL_W];

    lin_sum = {1'b0, lv_pre} + {1'b0, attack_step};

    if (attack_exponential) begin
      lv_rise = FULL_SCALE - scaled;
    end else if (lin_sum > {1'b0, FULL_SCALE}) begin
      lv_rise = FULL_SCALE;
    end else begin
      lv_rise = lin_sum[LEVEL_W-1:0];
    end

    if (release_exponential) begin
      lv_fall = scaled;
    end else if (release_step >= lv_pre) begin
      lv_fall = '0;
    end else begin
      lv_fall = lv_pre - release_step;
    end

    st_new.level = s1_item.gate_on ? lv_rise : lv_fall;
    st_new.count = (cnt_base == COUNT_MAX) ? cnt_base : cnt_base + COUNT_W'(1);
    st_new.gate  = s1_item.gate_on;

    result.out_channel     = s1_item.channel;
    result.in_release      = !s1_item.gate_on;
    result.level           = s1_in_range ? st_new.level : '0;
    result.elapsed_samples = s1_in_range ? cnt_base : '0;
  end

  // Output register: parts the compute stage from the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_go) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_go) begin
      rsp <= result;
    end
  end

  `ARE_ASSERT_NEXT(a_accept_enters_stage, req_valid && req_ready, s1_valid,
                   "accepted item did not reach the compute stage")
  `ARE_ASSERT_NEXT(a_stage_reaches_output, s1_valid && s1_go, rsp_valid,
                   "item leaving the compute stage did not reach the output")
  `ARE_ASSERT_NEXT(a_restart_clears_count, s1_valid && s1_go && s1_item.restart,
                   rsp.elapsed_samples == '0, "restart did not clear the sample count")
  `ARE_ASSERT_SAME(a_level_in_range, rsp_valid, rsp.level <= FULL_SCALE,
                   "level above full scale")

endmodule
